FILE: design/set_assoc_cache_tag_controller_unit_macros.svh
// assertion helpers for the cache tag controller
`ifndef SET_ASSOC_CACHE_TAG_CONTROLLER_UNIT_MACROS_SVH
`define SET_ASSOC_CACHE_TAG_CONTROLLER_UNIT_MACROS_SVH

// implication checked on every rising clock edge outside reset
`define SACT_ASSERT_IMPL(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error(msg);

// implication checked at the next rising clock edge
`define SACT_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error(msg);

`endif

FILE: design/sact_pkg.sv
package sact_pkg;

   localparam int SET_COUNT_DEF  = 64;
   localparam int WAYS_DEF       = 4;
   localparam int LINE_BYTES_DEF = 64;
   localparam int ADDR_BITS_DEF  = 32;

   localparam int TAG_W   = 20;
   localparam int SET_W   = 6;
   localparam int CNT_W   = 16;
   localparam int LFSR_W  = 16;
   localparam logic [LFSR_W-1:0] LFSR_TAPS = 16'hB400;
   localparam logic [LFSR_W-1:0] LFSR_SEED = 16'h0001;

   // line states
   localparam logic [1:0] ST_INVALID  = 2'd0;
   localparam logic [1:0] ST_VALID    = 2'd1;
   localparam logic [1:0] ST_MODIFIED = 2'd2;

   // replacement policies
   localparam logic [1:0] RM_LRU  = 2'd0;
   localparam logic [1:0] RM_MRU  = 2'd1;
   localparam logic [1:0] RM_LFU  = 2'd2;
   localparam logic [1:0] RM_RAND = 2'd3;

   // write policies
   localparam logic WM_THROUGH = 1'b0;
   localparam logic WM_BACK    = 1'b1;

   // register indexes
   localparam logic [0:0] CSR_REPLACE = 1'b0;
   localparam logic [0:0] CSR_WRITE   = 1'b1;
   localparam int CSR_IDX_W = 8;

   typedef struct packed {
      logic        req_type;
      logic [31:0] address;
   } req_type_type;

   typedef struct packed {
      logic             hit;
      logic             allocated;
      logic             writeback;
      logic [TAG_W-1:0] victim_tag;
      logic [SET_W-1:0] set_number;
   } rsp_type;

   typedef struct packed {
      logic [1:0] replace_mode;
      logic       write_mode;
   } cfg_type;

endpackage

FILE: design/set_assoc_cache_tag_controller_unit.sv
// Cache tag controller: looks up one access per command and reports the outcome.
// Request channel: an item is taken at a clock edge where start is high and busy
// low; req_data carries the access kind and byte address.
// Result channel: rsp_strobe is high for exactly one cycle with rsp_data; the
// receiver cannot hold results back, so the result side never stalls.
// Sequence: the set row is read at the accepting edge; in the read step the row
// is modify-written and the result registered. busy stays high through the read
// and write steps, so a new item is taken only once the result of the one
// before has been presented and the single set memory can be read again.
// Configuration: csr_valid/csr_ready write channel, index 0 replacement
// policy, index 1 write policy; csr_ready is always high.
// Reset: a clearing pass walks every set, one set a cycle, writing invalid
// states, zero counters and the index order; busy holds high until it ends.
// Policies return to LRU and write-back, LFSR to 1.
module set_assoc_cache_tag_controller_unit #(
   parameter int SET_COUNT  = sact_pkg::SET_COUNT_DEF,
   parameter int WAYS       = sact_pkg::WAYS_DEF,
   parameter int LINE_BYTES = sact_pkg::LINE_BYTES_DEF,
   parameter int ADDR_BITS  = sact_pkg::ADDR_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  sact_pkg::req_type_type          req_data,
   output logic                            rsp_strobe,
   output sact_pkg::rsp_type               rsp_data,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [sact_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [31:0]                     csr_data
);

`include "set_assoc_cache_tag_controller_unit_macros.svh"

   localparam int OFF_W = $clog2(LINE_BYTES + 1) - 1;
   localparam int IDX_BITS = $clog2(SET_COUNT + 1) - 1;
   localparam int IDX_W = (IDX_BITS < 1) ? 1 : IDX_BITS;
   localparam int ORD_W = (WAYS < 2) ? 1 : $clog2(WAYS);
   localparam int ROW_W = WAYS * (sact_pkg::TAG_W + 2 + sact_pkg::CNT_W + ORD_W);
   localparam int TW = sact_pkg::TAG_W;
   localparam int CW = sact_pkg::CNT_W;

   typedef enum logic [3:0] {
      S_CLEAR = 4'b0001,
      S_IDLE  = 4'b0010,
      S_READ  = 4'b0100,
      S_WRITE = 4'b1000
   } state_type;

   typedef struct packed {
      logic [WAYS-1:0][TW-1:0]    tags;
      logic [WAYS-1:0][1:0]       stat;
      logic [WAYS-1:0][CW-1:0]    cnt;
      logic [WAYS-1:0][ORD_W-1:0] ord;
   } row_type;

   state_type state_ff, state_in;
   logic [IDX_W-1:0] clr_ff, clr_in;
   logic [IDX_W-1:0] set_ff, set_in;
   logic [TW-1:0] tag_ff, tag_in;
   logic wr_ff, wr_in;
   sact_pkg::cfg_type cfg_ff, cfg_in;
   logic [sact_pkg::LFSR_W-1:0] lfsr_ff, lfsr_in, lfsr_next;
   logic rsp_strobe_ff, rsp_strobe_in;
   sact_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic [ADDR_BITS-1:0] addr_cut;
   logic [IDX_W-1:0] req_set;
   logic [TW-1:0] req_tag;
   row_type row_rd, row_wr, row_clr;
   logic [ROW_W-1:0] ram_rd;
   logic ram_we;
   logic [IDX_W-1:0] ram_waddr;
   logic [ROW_W-1:0] ram_wdata;
   logic lfsr_used, hit, allocated, writeback;
   logic [TW-1:0] victim_tag;
   logic accept;

   // address split
   always_comb begin
      addr_cut = '0;
      for (int b = 0; b < ADDR_BITS; b++) begin
         if (b < 32) begin
            addr_cut[b] = req_data.address[b];
         end
      end
      req_set = '0;
      if (IDX_BITS > 0) begin
         req_set = IDX_W'(addr_cut >> OFF_W);
      end
      req_tag = TW'(addr_cut >> (OFF_W + IDX_BITS));
   end

   assign busy = (state_ff != S_IDLE);
   assign accept = start && !busy;
   assign csr_ready = 1'b1;

   // clearing row: invalid, zero counts, index order
   always_comb begin
      row_clr = '0;
      for (int w = 0; w < WAYS; w++) begin
         row_clr.ord[w] = ORD_W'(w);
      end
   end

   assign row_rd = row_type'(ram_rd);

   // Galois step of the lfsr
   assign lfsr_next = lfsr_ff[0] ? ((lfsr_ff >> 1) ^ sact_pkg::LFSR_TAPS) : (lfsr_ff >> 1);

   sact_set_logic #(.WAYS(WAYS), .ORD_W(ORD_W)) u_set (
      .is_write   (wr_ff),
      .tag        (tag_ff),
      .cfg        (cfg_ff),
      .lfsr_next  (lfsr_next),
      .tags_rd    (row_rd.tags),
      .stat_rd    (row_rd.stat),
      .cnt_rd     (row_rd.cnt),
      .ord_rd     (row_rd.ord),
      .tags_wr    (row_wr.tags),
      .stat_wr    (row_wr.stat),
      .cnt_wr     (row_wr.cnt),
      .ord_wr     (row_wr.ord),
      .lfsr_used  (lfsr_used),
      .hit        (hit),
      .allocated  (allocated),
      .writeback  (writeback),
      .victim_tag (victim_tag)
   );

   assign ram_we = (state_ff == S_CLEAR) || (state_ff == S_READ);
   assign ram_waddr = (state_ff == S_CLEAR) ? clr_ff : set_ff;
   assign ram_wdata = (state_ff == S_CLEAR) ? ROW_W'(row_clr) : ROW_W'(row_wr);

   sact_ram #(.WIDTH(ROW_W), .DEPTH(1 << IDX_W)) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (req_set),
      .rd_data (ram_rd)
   );

   // sequencer
   always_comb begin
      state_in = state_ff;
      clr_in = clr_ff;
      set_in = set_ff;
      tag_in = tag_ff;
      wr_in = wr_ff;
      cfg_in = cfg_ff;
      lfsr_in = lfsr_ff;
      rsp_strobe_in = 1'b0;
      rsp_data_in = rsp_data_ff;
      if (csr_valid) begin
         if (csr_index == sact_pkg::CSR_IDX_W'(sact_pkg::CSR_REPLACE)) begin
            cfg_in.replace_mode = csr_data[1:0];
         end else if (csr_index == sact_pkg::CSR_IDX_W'(sact_pkg::CSR_WRITE)) begin
            cfg_in.write_mode = csr_data[0];
         end
      end
      unique case (state_ff)
         S_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == IDX_W'((1 << IDX_BITS) - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               set_in = req_set;
               tag_in = req_tag;
               wr_in = req_data.req_type;
               state_in = S_READ;
            end
         end
         S_READ: begin
            if (lfsr_used) begin
               lfsr_in = lfsr_next;
            end
            rsp_strobe_in = 1'b1;
            rsp_data_in.hit = hit;
            rsp_data_in.allocated = allocated;
            rsp_data_in.writeback = writeback;
            rsp_data_in.victim_tag = victim_tag;
            rsp_data_in.set_number = sact_pkg::SET_W'(set_ff);
            state_in = S_WRITE;
         end
         S_WRITE: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff <= '0;
         cfg_ff <= '{replace_mode: sact_pkg::RM_LRU, write_mode: sact_pkg::WM_BACK};
         lfsr_ff <= sact_pkg::LFSR_SEED;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         cfg_ff <= cfg_in;
         lfsr_ff <= lfsr_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      set_ff <= set_in;
      tag_ff <= tag_in;
      wr_ff <= wr_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data = rsp_data_ff;

   // checks
   `SACT_ASSERT_NEXT(a_item_result, clock, reset, accept, (state_ff == S_READ) && !rsp_strobe,
      "accepted item did not reach the read step")
   `SACT_ASSERT_NEXT(a_read_strobe, clock, reset, state_ff == S_READ, rsp_strobe,
      "result strobe missing after read step")
   `SACT_ASSERT_IMPL(a_hit_clean, clock, reset, rsp_strobe && rsp_data.hit,
      !rsp_data.allocated && !rsp_data.writeback,
      "hit reported with a fill")
   `SACT_ASSERT_IMPL(a_wb_alloc, clock, reset, rsp_strobe && rsp_data.writeback,
      rsp_data.allocated, "writeback without a fill")

endmodule

FILE: design/sact_ram.sv
module sact_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // single write port, registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/sact_set_logic.sv
// per-set lookup, victim choice and update of one set row
module sact_set_logic #(
   parameter int WAYS = 4,
   parameter int ORD_W = 2
) (
   input  logic                                 is_write,
   input  logic [sact_pkg::TAG_W-1:0]           tag,
   input  sact_pkg::cfg_type                    cfg,
   input  logic [sact_pkg::LFSR_W-1:0]          lfsr_next,
   input  logic [WAYS-1:0][sact_pkg::TAG_W-1:0] tags_rd,
   input  logic [WAYS-1:0][1:0]                 stat_rd,
   input  logic [WAYS-1:0][sact_pkg::CNT_W-1:0] cnt_rd,
   input  logic [WAYS-1:0][ORD_W-1:0]           ord_rd,
   output logic [WAYS-1:0][sact_pkg::TAG_W-1:0] tags_wr,
   output logic [WAYS-1:0][1:0]                 stat_wr,
   output logic [WAYS-1:0][sact_pkg::CNT_W-1:0] cnt_wr,
   output logic [WAYS-1:0][ORD_W-1:0]           ord_wr,
   output logic                                 lfsr_used,
   output logic                                 hit,
   output logic                                 allocated,
   output logic                                 writeback,
   output logic [sact_pkg::TAG_W-1:0]           victim_tag
);

   localparam int RND_SH = sact_pkg::LFSR_W + 5;
   localparam int RND_MW = RND_SH + 1;
   localparam int RND_W = sact_pkg::LFSR_W + RND_MW;
   localparam logic [RND_MW-1:0] RND_MUL = RND_MW'(((1 << RND_SH) + WAYS - 1) / WAYS);

   logic [WAYS-1:0] match;
   logic [ORD_W-1:0] hit_pos;
   logic [ORD_W-1:0] lfu_pos;
   logic [ORD_W-1:0] sel_pos;
   logic [ORD_W-1:0] sel_way;
   logic [sact_pkg::CNT_W-1:0] best_cnt;
   logic [RND_W-1:0] rnd_prod;
   logic [sact_pkg::LFSR_W-1:0] rnd_quot;
   logic [sact_pkg::LFSR_W-1:0] rnd_rem;
   logic fill;
   logic do_move;

   // tag compare per way in order of recency
   always_comb begin
      match = '0;
      hit = 1'b0;
      hit_pos = '0;
      for (int p = 0; p < WAYS; p++) begin
         match[p] = (stat_rd[ord_rd[p]] != sact_pkg::ST_INVALID) &&
                    (tags_rd[ord_rd[p]] == tag);
      end
      for (int p = WAYS - 1; p >= 0; p--) begin
         if (match[p]) begin
            hit = 1'b1;
            hit_pos = ORD_W'(p);
         end
      end
   end

   // first position with the smallest counter
   always_comb begin
      lfu_pos = '0;
      best_cnt = cnt_rd[ord_rd[0]];
      for (int p = 1; p < WAYS; p++) begin
         if (cnt_rd[ord_rd[p]] < best_cnt) begin
            best_cnt = cnt_rd[ord_rd[p]];
            lfu_pos = ORD_W'(p);
         end
      end
   end

   // lfsr value modulo the way count by reciprocal multiplication
   always_comb begin
      rnd_prod = RND_W'(lfsr_next) * RND_W'(RND_MUL);
      rnd_quot = rnd_prod[RND_SH +: sact_pkg::LFSR_W];
      rnd_rem = lfsr_next - sact_pkg::LFSR_W'(rnd_quot * sact_pkg::LFSR_W'(WAYS));
   end

   assign fill = !hit && !(is_write && cfg.write_mode == sact_pkg::WM_THROUGH);
   assign lfsr_used = fill && cfg.replace_mode == sact_pkg::RM_RAND;

   // position moved to the front
   always_comb begin
      sel_pos = '0;
      if (hit) begin
         sel_pos = hit_pos;
      end else begin
         unique case (cfg.replace_mode)
            sact_pkg::RM_LRU:  sel_pos = ORD_W'(WAYS - 1);
            sact_pkg::RM_MRU:  sel_pos = '0;
            sact_pkg::RM_LFU:  sel_pos = lfu_pos;
            sact_pkg::RM_RAND: sel_pos = ORD_W'(rnd_rem);
            default:           sel_pos = '0;
         endcase
      end
   end

   assign do_move = hit || fill;
   assign sel_way = ord_rd[sel_pos];

   // new order, tags, states and counters
   always_comb begin
      ord_wr = ord_rd;
      tags_wr = tags_rd;
      stat_wr = stat_rd;
      cnt_wr = cnt_rd;
      writeback = 1'b0;
      victim_tag = '0;
      if (do_move) begin
         for (int p = 1; p < WAYS; p++) begin
            if (ORD_W'(p) <= sel_pos) begin
               ord_wr[p] = ord_rd[p-1];
            end
         end
         ord_wr[0] = sel_way;
      end
      if (hit) begin
         if (cnt_rd[sel_way] != '1) begin
            cnt_wr[sel_way] = cnt_rd[sel_way] + 1'b1;
         end
         if (is_write && cfg.write_mode == sact_pkg::WM_BACK) begin
            stat_wr[sel_way] = sact_pkg::ST_MODIFIED;
         end
      end else if (fill) begin
         if (stat_rd[sel_way] == sact_pkg::ST_MODIFIED) begin
            writeback = 1'b1;
            victim_tag = tags_rd[sel_way];
         end
         tags_wr[sel_way] = tag;
         stat_wr[sel_way] = (is_write && cfg.write_mode == sact_pkg::WM_BACK) ?
                            sact_pkg::ST_MODIFIED : sact_pkg::ST_VALID;
         cnt_wr[sel_way] = '0;
      end
   end

   assign allocated = fill;

endmodule

FILE: test/set_assoc_cache_tag_controller_unit_tb.sv
`timescale 1ns / 1ps

module set_assoc_cache_tag_controller_unit_tb;

   localparam int N_SETS = 64;
   localparam int N_WAYS = 4;
   localparam int WATCHDOG_LIMIT = 2000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   sact_pkg::req_type_type req_data = '0;
   logic rsp_strobe;
   sact_pkg::rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [sact_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [31:0] csr_data = '0;

   // cache image kept by the testbench
   logic [sact_pkg::TAG_W-1:0] img_tag [N_SETS*N_WAYS];
   logic [1:0] img_status [N_SETS*N_WAYS];
   logic [sact_pkg::CNT_W-1:0] img_count [N_SETS*N_WAYS];
   int img_order [N_SETS][N_WAYS];
   logic [sact_pkg::LFSR_W-1:0] img_lfsr;
   logic [1:0] cur_replace;
   logic cur_write;

   sact_pkg::rsp_type outcome_q [$];
   int errors = 0;
   int idle_cycles = 0;
   // small pool of tags so that sets fill up and hits occur
   logic [sact_pkg::TAG_W-1:0] tag_pool [8];

   set_assoc_cache_tag_controller_unit dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_strobe(rsp_strobe), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // shift one way of the order to the front
   function automatic void promote(int s, int p);
      int w;
      w = img_order[s][p];
      for (int i = p; i > 0; i--) img_order[s][i] = img_order[s][i-1];
      img_order[s][0] = w;
   endfunction

   function automatic sact_pkg::rsp_type predict_access(sact_pkg::req_type_type r);
      sact_pkg::rsp_type o;
      int s, li, best, p;
      logic [sact_pkg::TAG_W-1:0] t;
      logic wr;
      logic lsb;
      o = '0;
      wr = r.req_type;
      s = int'(r.address[11:6]);
      t = r.address[31:12];
      o.set_number = sact_pkg::SET_W'(s);
      for (p = 0; p < N_WAYS; p++) begin
         li = s*N_WAYS + img_order[s][p];
         if (img_status[li] != sact_pkg::ST_INVALID && img_tag[li] == t) begin
            o.hit = 1'b1;
            promote(s, p);
            if (img_count[li] != '1) img_count[li]++;
            if (wr && cur_write == sact_pkg::WM_BACK) img_status[li] = sact_pkg::ST_MODIFIED;
            break;
         end
      end
      if (!o.hit && !(wr && cur_write == sact_pkg::WM_THROUGH)) begin
         unique case (cur_replace)
            sact_pkg::RM_LRU: promote(s, N_WAYS-1);
            sact_pkg::RM_MRU: ;
            sact_pkg::RM_LFU: begin
               best = 0;
               for (p = 1; p < N_WAYS; p++)
                  if (img_count[s*N_WAYS+img_order[s][p]] <
                      img_count[s*N_WAYS+img_order[s][best]]) best = p;
               promote(s, best);
            end
            sact_pkg::RM_RAND: begin
               lsb = img_lfsr[0];
               img_lfsr = img_lfsr >> 1;
               if (lsb) img_lfsr ^= sact_pkg::LFSR_TAPS;
               promote(s, int'(img_lfsr) % N_WAYS);
            end
         endcase
         li = s*N_WAYS + img_order[s][0];
         if (img_status[li] == sact_pkg::ST_MODIFIED) begin
            o.writeback = 1'b1;
            o.victim_tag = img_tag[li];
         end
         img_tag[li] = t;
         img_status[li] = (wr && cur_write == sact_pkg::WM_BACK) ?
                          sact_pkg::ST_MODIFIED : sact_pkg::ST_VALID;
         img_count[li] = '0;
         o.allocated = 1'b1;
      end
      return o;
   endfunction

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (outcome_q.size() == 0) begin
            $display("%0t: unexpected result %p", $time, rsp_data);
            errors++;
         end else begin
            sact_pkg::rsp_type e;
            e = outcome_q.pop_front();
            if (rsp_data.hit !== e.hit)
               $display("%0t: hit exp %0d got %0d", $time, e.hit, rsp_data.hit);
            if (rsp_data.allocated !== e.allocated)
               $display("%0t: allocated exp %0d got %0d", $time, e.allocated,
                        rsp_data.allocated);
            if (rsp_data.writeback !== e.writeback)
               $display("%0t: writeback exp %0d got %0d", $time, e.writeback,
                        rsp_data.writeback);
            if (rsp_data.victim_tag !== e.victim_tag)
               $display("%0t: victim_tag exp %h got %h", $time, e.victim_tag,
                        rsp_data.victim_tag);
            if (rsp_data.set_number !== e.set_number)
               $display("%0t: set_number exp %0d got %0d", $time, e.set_number,
                        rsp_data.set_number);
            if (rsp_data !== e) errors++;
         end
      end
   end

   // watchdog on cycles with no accepted item, register write or result
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end else
         idle_cycles <= idle_cycles + 1;
   end

   // start stays high after acceptance until the next item or a drain
   task automatic send_access(logic wr, logic [31:0] addr, bit no_gap = 0);
      sact_pkg::req_type_type r;
      int gap;
      gap = no_gap ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      r.req_type = wr;
      r.address = addr;
      start <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy);
      outcome_q.insert(outcome_q.size(), predict_access(r));
   endtask

   task automatic drain();
      start <= 1'b0;
      while (outcome_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(logic [sact_pkg::CSR_IDX_W-1:0] idx, logic [31:0] val);
      drain();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == sact_pkg::CSR_IDX_W'(sact_pkg::CSR_REPLACE)) cur_replace = val[1:0];
      else cur_write = val[0];
   endtask

   function automatic logic [31:0] pick_addr();
      logic [31:0] a;
      a = $urandom;
      a[31:12] = tag_pool[$urandom_range(0, 7)];
      a[11:6] = 6'($urandom_range(0, 3));
      return a;
   endfunction

   task automatic test_directed();
      // address extremes, read and write misses, hits, dirty eviction
      send_access(1'b0, 32'h0000_0000);
      send_access(1'b0, 32'hFFFF_FFFF);
      send_access(1'b1, 32'h0000_003F);
      send_access(1'b1, 32'hFFFF_FFC0);
      for (int i = 1; i <= 5; i++) send_access(1'b1, {20'(i), 6'd0, 6'd0});
      send_access(1'b0, 32'h0000_0000);
      // write-through: write miss without fill, then dirty line eviction
      write_csr(sact_pkg::CSR_IDX_W'(sact_pkg::CSR_WRITE), 32'(sact_pkg::WM_THROUGH));
      send_access(1'b1, 32'hABCD_E000);
      for (int i = 6; i <= 9; i++) send_access(1'b0, {20'(i), 6'd0, 6'd0});
      send_access(1'b1, 32'h0000_9000);
      write_csr(sact_pkg::CSR_IDX_W'(sact_pkg::CSR_WRITE), 32'(sact_pkg::WM_BACK));
   endtask

   task automatic test_policy(logic [1:0] mode, int n);
      write_csr(sact_pkg::CSR_IDX_W'(sact_pkg::CSR_REPLACE), 32'(mode));
      for (int i = 0; i < n; i++) begin
         // every so often run a burst with no gaps
         send_access(1'($urandom_range(0, 1)), pick_addr(), (i % 50) < 10);
         if ((i % 97) == 96)
            write_csr(sact_pkg::CSR_IDX_W'(sact_pkg::CSR_WRITE), 32'($urandom_range(0, 1)));
      end
   endtask

   task automatic test_random_full(int n);
      for (int i = 0; i < n; i++) send_access(1'($urandom_range(0, 1)), $urandom);
   endtask

   initial begin
      for (int i = 0; i < N_SETS*N_WAYS; i++) begin
         img_tag[i] = '0;
         img_status[i] = sact_pkg::ST_INVALID;
         img_count[i] = '0;
      end
      for (int s = 0; s < N_SETS; s++)
         for (int w = 0; w < N_WAYS; w++) img_order[s][w] = w;
      img_lfsr = sact_pkg::LFSR_SEED;
      cur_replace = sact_pkg::RM_LRU;
      cur_write = sact_pkg::WM_BACK;
      for (int i = 0; i < 8; i++) tag_pool[i] = sact_pkg::TAG_W'($urandom);
      tag_pool[0] = '0;
      tag_pool[1] = '1;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_policy(sact_pkg::RM_LRU, 350);
      test_policy(sact_pkg::RM_MRU, 300);
      test_policy(sact_pkg::RM_LFU, 350);
      test_policy(sact_pkg::RM_RAND, 350);
      write_csr(sact_pkg::CSR_IDX_W'(sact_pkg::CSR_WRITE), 32'(sact_pkg::WM_BACK));
      test_policy(sact_pkg::RM_LRU, 0);
      test_random_full(180);
      drain();
      repeat (10) @(posedge clock);
      if (errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
